### sv/wfc_pkg.sv
// wfc_pkg: shared types, constants and helpers of the wall-follow wheel speed control unit
// no dependencies; imported by the controller, the datapath and the top level

package wfc_pkg;

  // field widths
  localparam int StepsW  = 16;
  localparam int SensorW = 12;
  localparam int SpeedW  = 6;
  localparam int CountW  = 8;
  localparam int BaseW   = 5;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 72;
  localparam int OutDataW = 32;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegStraightRunSteps   = 2'd0;
  localparam logic [CfgAddrW-1:0] RegFrontObstacleLimit = 2'd1;
  localparam int                  RegRaisedWallTarget   = 2;

  // reset values
  localparam logic [StepsW-1:0]  StraightRunReset = 16'd300;
  localparam logic [SensorW-1:0] FrontLimitReset  = 12'd1000;
  localparam logic [SensorW-1:0] RaisedReset      = 12'd400;
  localparam logic [SensorW-1:0] WallTargetReset  = 12'd400;

  // law constants
  localparam int StepsPerBase = 150;
  localparam int BaseStepMax  = 13;
  localparam logic [StepsW-1:0]  JamStepLimit  = 16'd2000;
  localparam logic [SensorW-1:0] HighGainLimit = 12'd200;
  localparam logic [CountW-1:0]  CountMax      = 8'd255;

  // iterative divider
  localparam int DivNumW  = 19;
  localparam int DivSteps = DivNumW;
  localparam int DivCntW  = 5;

  // reciprocal multipliers for the constant divisions
  localparam logic [15:0] Recip9  = 16'd58255;  // 2^19 / 9, rounded up
  localparam logic [15:0] Recip10 = 16'd52429;  // 2^19 / 10, rounded up
  localparam logic [15:0] Recip3  = 16'd43691;  // 2^17 / 3, rounded up

  // shared multiplier operand select
  localparam logic [1:0] MulProp9  = 2'd0;
  localparam logic [1:0] MulProp10 = 2'd1;
  localparam logic [1:0] MulDelta3 = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       straight_en;
    logic       obstacle_en;
    logic       div_start;
    logic       div_step;
    logic       prop_en;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       law_en;
    logic       out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic straight;
    logic obstacle;
    logic div_last;
  } status_t;

  // stepped base speed from the far wheel: 15 + steps/150, capped at 28
  function automatic logic [BaseW-1:0] stepped_base(input logic [StepsW-1:0] steps);
    logic [BaseW-1:0] cnt;
    cnt = '0;
    for (int k = 1; k <= BaseStepMax; k++) begin
      if (steps >= StepsW'(StepsPerBase * k)) cnt = BaseW'(k);
    end
    return BaseW'(15) + cnt;
  endfunction

  // magnitude and sign back to an 18-bit signed value
  function automatic logic signed [17:0] to_signed18(input logic [15:0] mag,
                                                     input logic neg);
    logic signed [17:0] v;
    v = $signed({2'b00, mag});
    return neg ? -v : v;
  endfunction

endpackage

### sv/wfc_ctrl.sv
// wfc_ctrl: sequencing state machine of the wall-follow wheel speed control unit
// depends on wfc_pkg; drives the datapath with cmd_t and reads status_t

module wfc_ctrl import wfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  output logic    m_axis_tvalid,
  input  logic    m_axis_tready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StClassify = 3'd1;
  localparam logic [2:0] StDivide   = 3'd2;
  localparam logic [2:0] StProp     = 3'd3;
  localparam logic [2:0] StMul      = 3'd4;
  localparam logic [2:0] StLaw      = 3'd5;
  localparam logic [2:0] StFinish   = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] mul_sel, mul_sel_next;
  logic       out_free;

  assign s_axis_tready = (state == StIdle);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // next state and commands
  always_comb begin
    state_next   = state;
    mul_sel_next = mul_sel;
    cmd          = '0;
    cmd.mul_sel  = mul_sel;
    unique case (state)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = StClassify;
        end
      end
      StClassify: begin
        if (status.straight) begin
          cmd.straight_en = 1'b1;
          state_next      = StFinish;
        end else if (status.obstacle) begin
          cmd.obstacle_en = 1'b1;
          state_next      = StFinish;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = StDivide;
        end
      end
      StDivide: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = StProp;
      end
      StProp: begin
        cmd.prop_en  = 1'b1;
        mul_sel_next = MulProp9;
        state_next   = StMul;
      end
      StMul: begin
        cmd.mul_en = 1'b1;
        unique case (mul_sel)
          MulProp9:  mul_sel_next = MulProp10;
          MulProp10: mul_sel_next = MulDelta3;
          default:   state_next   = StLaw;
        endcase
      end
      StLaw: begin
        cmd.law_en = 1'b1;
        state_next = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StIdle;
      mul_sel       <= MulProp9;
      m_axis_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      mul_sel <= mul_sel_next;
      if (cmd.out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

endmodule

### sv/wfc_datapath.sv
// wfc_datapath: configuration registers, control state, divider, multiplier and speed law
// depends on wfc_pkg; commanded by wfc_ctrl

module wfc_datapath import wfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [InDataW-1:0]  in_data,
  input  cmd_t                cmd,
  output status_t             status,
  output logic [OutDataW-1:0] out_data
);

  // configuration
  logic [StepsW-1:0]  straight_run_steps;
  logic [SensorW-1:0] front_obstacle_limit;
  logic [SensorW-1:0] raised_wall_target;

  // latched input beat
  logic [StepsW-1:0]  left_wheel_steps, right_wheel_steps;
  logic [SensorW-1:0] front_obstacle, left_wall_reading, right_wall_reading;
  logic               follow_left;

  // control state
  logic [SensorW-1:0]  wall_target;
  logic signed [15:0]  previous_error;
  logic [CountW-1:0]   jam_counter, sharp_turn_counter;
  logic [SpeedW-1:0]   held_left_drive, held_right_drive;
  logic                turn_request;

  // work registers
  logic [DivNumW-1:0]  div_num;
  logic [SensorW-1:0]  div_rem, divisor;
  logic [DivCntW-1:0]  div_cnt;
  logic signed [15:0]  prop;
  logic signed [16:0]  delta;
  logic [BaseW-1:0]    base;
  logic [11:0]         prop_q9, prop_q10;
  logic [13:0]         delta_q3;

  logic [StepsW-1:0]  near_steps, far_steps;
  logic [SensorW-1:0] wall;
  assign near_steps = follow_left ? left_wheel_steps : right_wheel_steps;
  assign far_steps  = follow_left ? right_wheel_steps : left_wheel_steps;
  assign wall       = follow_left ? left_wall_reading : right_wall_reading;

  assign status.straight = near_steps < straight_run_steps;
  assign status.obstacle = front_obstacle >= front_obstacle_limit;
  assign status.div_last = div_cnt == DivCntW'(DivSteps - 1);

  // configuration writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      straight_run_steps   <= StraightRunReset;
      front_obstacle_limit <= FrontLimitReset;
      raised_wall_target   <= RaisedReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegStraightRunSteps:   straight_run_steps   <= cfg_data;
        RegFrontObstacleLimit: front_obstacle_limit <= cfg_data[SensorW-1:0];
        CfgAddrW'(RegRaisedWallTarget): raised_wall_target <= cfg_data[SensorW-1:0];
        default: ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      left_wheel_steps   <= in_data[15:0];
      right_wheel_steps  <= in_data[31:16];
      front_obstacle     <= in_data[43:32];
      left_wall_reading  <= in_data[55:44];
      right_wall_reading <= in_data[67:56];
      follow_left        <= in_data[68];
    end
  end

  // restoring divider: one quotient bit per cycle, quotient shifts into div_num
  logic [DivNumW-1:0] wall_x100;
  logic [SensorW:0]   rem_shift, rem_sub;
  assign wall_x100 = {1'b0, wall, 6'b0} + {2'b0, wall, 5'b0} + {5'b0, wall, 2'b0};
  assign rem_shift = {div_rem, div_num[DivNumW-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num <= wall_x100;
      div_rem <= '0;
      div_cnt <= '0;
      divisor <= (wall_target == '0) ? SensorW'(1) : wall_target;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DivCntW'(1);
      if (!rem_sub[SensorW]) begin
        div_rem <= rem_sub[SensorW-1:0];
        div_num <= {div_num[DivNumW-2:0], 1'b1};
      end else begin
        div_rem <= rem_shift[SensorW-1:0];
        div_num <= {div_num[DivNumW-2:0], 1'b0};
      end
    end
  end

  // proportion with saturation, difference term and base speed
  logic signed [15:0] prop_calc;
  logic [DivNumW-1:0] q_minus;
  assign q_minus   = div_num - DivNumW'(100);
  assign prop_calc = (div_num > DivNumW'(32867)) ? 16'sd32767 : $signed(q_minus[15:0]);

  always_ff @(posedge clk) begin
    if (cmd.prop_en) begin
      prop  <= prop_calc;
      delta <= {prop_calc[15], prop_calc} - {previous_error[15], previous_error};
      base  <= stepped_base(far_steps);
    end
  end

  // shared reciprocal multiplier for /9, /10 and /3 on magnitudes
  logic [15:0] prop_abs_w, delta_abs, mul_a, mul_b;
  logic [16:0] delta_neg_v;
  logic [15:0] prop_neg_v;
  logic [31:0] product;
  assign prop_neg_v  = -prop;
  assign delta_neg_v = -delta;
  assign prop_abs_w  = prop[15] ? prop_neg_v : prop;
  assign delta_abs   = delta[16] ? delta_neg_v[15:0] : delta[15:0];

  always_comb begin
    case (cmd.mul_sel)
      MulProp9:  begin mul_a = prop_abs_w; mul_b = Recip9;  end
      MulProp10: begin mul_a = prop_abs_w; mul_b = Recip10; end
      default:   begin mul_a = delta_abs;  mul_b = Recip3;  end
    endcase
  end
  assign product = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MulProp9:  prop_q9  <= product[30:19];
        MulProp10: prop_q10 <= product[30:19];
        default:   delta_q3 <= product[30:17];
      endcase
    end
  end

  // speed law, overrides and clamps
  logic signed [17:0] base_s, p8, p9, p10, d3, d4, ls, rs;
  logic [CountW-1:0]  sharp_next;
  logic               high_gain;

  always_comb begin
    base_s    = to_signed18({11'd0, base}, 1'b0);
    p8        = to_signed18({3'd0, prop_abs_w[15:3]}, prop[15]);
    p9        = to_signed18({4'd0, prop_q9}, prop[15]);
    p10       = to_signed18({4'd0, prop_q10}, prop[15]);
    d3        = to_signed18({2'd0, delta_q3}, delta[16]);
    d4        = to_signed18({2'd0, delta_abs[15:2]}, delta[16]);
    high_gain = wall_target > HighGainLimit;
    sharp_next = sharp_turn_counter;
    if (high_gain) begin
      ls = base_s + p8 + d3;
      rs = base_s - p9 - d3;
      if (base_s < 18'sd26) begin
        sharp_next = '0;
        if (rs > base_s + 18'sd6) begin
          rs = 18'sd34; ls = 18'sd4;
        end else if (ls > base_s + 18'sd10) begin
          rs = 18'sd5; ls = 18'sd30;
        end
      end else if (rs > 18'sd35) begin
        if (sharp_turn_counter < CountMax) sharp_next = sharp_turn_counter + CountW'(1);
        rs = 18'sd35; ls = 18'sd4;
      end else begin
        sharp_next = '0;
      end
    end else begin
      ls = base_s + p10 + d3;
      rs = base_s - p10 - d4;
      if (base_s < 18'sd26) begin
        sharp_next = '0;
        if (rs > base_s + 18'sd4) begin
          rs = 18'sd34; ls = 18'sd4;
        end
      end else if (rs > 18'sd32) begin
        if (sharp_turn_counter < CountMax) sharp_next = sharp_turn_counter + CountW'(1);
        rs = 18'sd36; ls = 18'sd4;
      end else begin
        sharp_next = '0;
      end
    end
    if (ls > 18'sd39) ls = 18'sd39;
    if (ls < 18'sd0)  ls = 18'sd0;
    if (rs > 18'sd35) rs = 18'sd35;
    if (rs < 18'sd5)  rs = 18'sd5;
  end

  // straight-run speed from the near wheel
  logic [SpeedW-1:0] straight_speed;
  assign straight_speed = (near_steps < 16'd100) ? 6'd10 :
                          (near_steps < 16'd500) ? 6'd15 : 6'd23;

  // control state update
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_target        <= WallTargetReset;
      previous_error     <= '0;
      jam_counter        <= '0;
      sharp_turn_counter <= '0;
      held_left_drive    <= '0;
      held_right_drive   <= '0;
      turn_request       <= 1'b0;
    end else if (cmd.straight_en) begin
      held_left_drive  <= straight_speed;
      held_right_drive <= straight_speed;
      turn_request     <= 1'b0;
    end else if (cmd.obstacle_en) begin
      if (far_steps < JamStepLimit && jam_counter < CountMax)
        jam_counter <= jam_counter + CountW'(1);
      turn_request <= 1'b1;
      wall_target  <= raised_wall_target;
    end else if (cmd.law_en) begin
      previous_error     <= prop;
      sharp_turn_counter <= sharp_next;
      held_left_drive    <= ls[SpeedW-1:0];
      held_right_drive   <= rs[SpeedW-1:0];
      turn_request       <= 1'b0;
    end
  end

  // output register with side swap
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data[5:0]   <= follow_left ? held_left_drive : held_right_drive;
      out_data[11:6]  <= follow_left ? held_right_drive : held_left_drive;
      out_data[12]    <= turn_request;
      out_data[20:13] <= jam_counter;
      out_data[28:21] <= sharp_turn_counter;
      out_data[31:29] <= '0;
    end
  end

endmodule

### sv/wall_follow_wheel_speed_control_unit.sv
// wall_follow_wheel_speed_control_unit: top level, controller plus datapath
// depends on wfc_pkg, wfc_ctrl and wfc_datapath
// flow: the beat is latched and classified, then goes to the output register in the straight
//   run or on a front obstacle, else first through the divider by wall_target, proportion,
//   multiplier and speed law; one beat at a time, and the result waits while the output stalls
// reset (rst, synchronous): registers to defaults, wall target 400, counters and speeds zero

module wall_follow_wheel_speed_control_unit import wfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // lowest bit up: left_wheel_steps[15:0], right_wheel_steps[31:16], front_obstacle[43:32],
  // left_wall_reading[55:44], right_wall_reading[67:56], follow_left[68], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // lowest bit up: followed-wall side wheel command[5:0], other wheel command[11:6], turn_request[12],
  // jam_count[20:13], special_turn_count[28:21], zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // configuration always taken
  assign cfg_ready = 1'b1;

  wfc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  wfc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_data (m_axis_tdata)
  );

endmodule
